// File: design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared definitions for the first-fit paragraph allocator
// Header layout, operation codes, controller states and header helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int MAX_PARAGRAPHS = 65536;
    localparam int SEG_W   = $clog2(MAX_PARAGRAPHS);
    localparam int NSEG_W  = SEG_W + 2;
    localparam int HDR_W   = 23;
    localparam int SIZE_W  = 21;
    localparam int REQ_W   = 20;
    localparam int FB_W    = 32;
    localparam int CNT_W   = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam int HB_VALID = 22;
    localparam int HB_FREE  = 1;
    localparam int HB_TERM  = 0;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    localparam logic [SEG_W-1:0]  START_RESET = 16'd4097;
    localparam logic [SEG_W-1:0]  END_RESET   = 16'd40960;
    localparam logic [SIZE_W-1:0] SLACK       = 21'h20;

    typedef logic [HDR_W-1:0] hdr_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_FMT_ROOT,
        S_FMT_END,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_COL_RD,
        S_COL_CHK,
        S_COL_END,
        S_SHAPE,
        S_SPLIT,
        S_BLK_CHK,
        S_RESP
    } state_t;

    function automatic logic [SIZE_W-1:0] hdr_size(input hdr_t h);
        return {h[20:2], 2'b00};
    endfunction

    function automatic hdr_t mk_hdr(input logic valid, input logic [SIZE_W-1:0] size,
                                    input logic free, input logic term);
        return {valid, 1'b0, size[20:2], free, term};
    endfunction

    // Data segment of the block that follows a block of the given size.
    function automatic logic [NSEG_W-1:0] next_seg(input logic [NSEG_W-1:0] base,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] s;
        s = {1'b0, size} + (SIZE_W+1)'(4);
        return base + s[SIZE_W:4];
    endfunction

    // Size of the single free block that a freshly formatted arena holds.
    function automatic logic [FB_W-1:0] fmt_free(input logic [SEG_W-1:0] s,
                                                 input logic [SEG_W-1:0] e);
        logic [SEG_W+3:0] t;
        logic [SEG_W-1:0] d;
        d = e - s;
        t = {d, 4'b0000} - (SEG_W+4)'(4);
        return (e > s) ? {{(FB_W-SEG_W-4){1'b0}}, t} : '0;
    endfunction

    localparam logic [FB_W-1:0] FB_RESET = fmt_free(START_RESET, END_RESET);

endpackage

`default_nettype wire

// File: design/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/first_fit_paragraph_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_paragraph_allocator: first-fit allocator over a paragraph arena
// Block headers live in one RAM indexed by data segment; a controller walks,
// merges and splits blocks with read-modify-write accesses.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready (func, request_bytes,
// block_segment, exact_fit); one result item per request leaves on
// out_valid/out_ready. The APB port holds the arena start and end segments.
// Steps: free checks the block and, if it is owned, sets its free bit, and an
// allocate larger than the free byte count goes straight to the response.
// Allocate and query read and check each block on the walk, merge every free
// block with the free blocks after it and write the merged header back, and
// end at the terminal header with the response; a fitting allocate ends instead
// with shape, an optional split and the response. Resize checks and merges the
// block, then shapes, optionally splits and responds, all on one header RAM.
// One item is worked on at a time; the next is taken as soon as the
// controller is back in idle, even while the previous result still waits
// in the output register. A stalled receiver holds the block in its
// response step only when a second result is ready.
// Reset and every write to either register start a clearing pass over all
// 65536 entries of the header RAM, followed by the format steps, during
// which in_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_paragraph_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ffpa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ffpa_pkg::DATA_W-1:0] pwdata,
    output logic      [ffpa_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [ffpa_pkg::REQ_W-1:0]  request_bytes,
    input  wire logic [ffpa_pkg::SEG_W-1:0]  block_segment,
    input  wire logic                        exact_fit,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             status,
    output logic      [ffpa_pkg::SEG_W-1:0]  result_segment,
    output logic      [ffpa_pkg::SIZE_W-1:0] result_bytes,
    output logic      [ffpa_pkg::CNT_W-1:0]  allocated_blocks
);

    import ffpa_pkg::*;

    state_t state_reg, state_next;

    logic [SEG_W-1:0]  start_reg, start_next, end_reg, end_next;
    logic [SEG_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [FB_W-1:0]   fbytes_reg, fbytes_next;
    logic [CNT_W-1:0]  bcount_reg, bcount_next;
    logic [NSEG_W-1:0] cur_reg, cur_next, nx_reg, nx_next;
    hdr_t              hdr_reg, hdr_next;
    logic [SIZE_W-1:0] sz_reg, sz_next, org_reg, org_next, best_reg, best_next;
    logic [SIZE_W-1:0] req_reg, req_next, nsz_reg, nsz_next;
    logic [1:0]        func_reg, func_next;
    logic              exact_reg, exact_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              res_status_reg, res_status_next;
    logic [SEG_W-1:0]  res_seg_reg, res_seg_next;
    logic [SIZE_W-1:0] res_bytes_reg, res_bytes_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [SEG_W-1:0]  out_seg_reg, out_seg_next;
    logic [SIZE_W-1:0] out_bytes_reg, out_bytes_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              mem_we;
    logic [SEG_W-1:0]  mem_waddr, mem_raddr;
    hdr_t              mem_wdata, mem_rdata;

    logic              cfg_wr, in_acc, arena_ok, walk_stop, rd_free, blk_ok;
    logic              col_fit, out_load, split;
    logic [SIZE_W:0]   col_sum, round_sum;
    logic [SIZE_W-1:0] rd_size, diff, nsz_calc, req_adj;
    logic [NSEG_W-1:0] split_seg;
    logic [SEG_W-1:0]  new_start, new_end;

    ffpa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (MAX_PARAGRAPHS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready   = 1'b1;
    assign prdata   = {{(DATA_W-SEG_W){1'b0}}, (paddr[2] == REG_END) ? end_reg : start_reg};
    assign cfg_wr   = psel & penable & pwrite;
    assign new_start = (paddr[2] == REG_START) ? pwdata[SEG_W-1:0] : start_reg;
    assign new_end   = (paddr[2] == REG_END) ? pwdata[SEG_W-1:0] : end_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign arena_ok = end_reg > start_reg;

    assign rd_size   = hdr_size(mem_rdata);
    assign rd_free   = mem_rdata[HB_VALID] & mem_rdata[HB_FREE];
    assign walk_stop = !mem_rdata[HB_VALID] || (mem_rdata == mk_hdr(1'b1, '0, 1'b0, 1'b1));
    assign blk_ok    = (seg_reg >= start_reg) && (seg_reg < end_reg) && mem_rdata[HB_VALID]
                       && !mem_rdata[HB_FREE] && !mem_rdata[HB_TERM];
    assign col_sum   = {1'b0, sz_reg} + {1'b0, rd_size} + (SIZE_W+1)'(4);
    assign col_fit   = sz_reg >= req_reg;
    assign req_adj   = (sz_reg < req_reg) ? (exact_reg ? org_reg : sz_reg) : req_reg;

    // The shape step splits off the tail when more than the slack is left.
    assign diff      = sz_reg - req_reg;
    assign split     = diff > SLACK;
    assign round_sum = {1'b0, req_reg} + (SIZE_W+1)'(19);
    assign nsz_calc  = split ? ({round_sum[SIZE_W-1:4], 4'b0000} - SIZE_W'(4)) : sz_reg;
    assign split_seg = next_seg(cur_reg, nsz_reg);
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (&clr_cnt_reg) state_next = S_FMT_ROOT;
            S_FMT_ROOT: state_next = S_FMT_END;
            S_FMT_END:  state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == FUNC_FREE || func == FUNC_RESIZE)
                        state_next = S_BLK_CHK;
                    else if (func == FUNC_ALLOC && {12'b0, request_bytes} > fbytes_reg)
                        state_next = S_RESP;
                    else
                        state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:  state_next = (cur_reg[NSEG_W-1:SEG_W] != '0) ? S_RESP : S_WALK_CHK;
            S_WALK_CHK:
            begin
                if (walk_stop)
                    state_next = S_RESP;
                else if (mem_rdata[HB_FREE])
                    state_next = S_COL_RD;
                else
                    state_next = S_WALK_RD;
            end
            S_COL_RD:   state_next = (nx_reg[NSEG_W-1:SEG_W] != '0) ? S_COL_END : S_COL_CHK;
            S_COL_CHK:  state_next = rd_free ? S_COL_RD : S_COL_END;
            S_COL_END:
            begin
                if (func_reg == FUNC_RESIZE || (func_reg == FUNC_ALLOC && col_fit))
                    state_next = S_SHAPE;
                else
                    state_next = S_WALK_RD;
            end
            S_SHAPE:    state_next = split ? S_SPLIT : S_RESP;
            S_SPLIT:    state_next = S_RESP;
            S_BLK_CHK:
            begin
                if (blk_ok && func_reg == FUNC_RESIZE)
                    state_next = S_COL_RD;
                else
                    state_next = S_RESP;
            end
            S_RESP:     if (out_load) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
        if (cfg_wr)
        begin
            state_next = S_CLEAR;
        end
    end

    always_comb
    begin
        start_next      = start_reg;
        end_next        = end_reg;
        clr_cnt_next    = clr_cnt_reg;
        fbytes_next     = fbytes_reg;
        bcount_next     = bcount_reg;
        cur_next        = cur_reg;
        nx_next         = nx_reg;
        hdr_next        = hdr_reg;
        sz_next         = sz_reg;
        org_next        = org_reg;
        best_next       = best_reg;
        req_next        = req_reg;
        nsz_next        = nsz_reg;
        func_next       = func_reg;
        exact_next      = exact_reg;
        seg_next        = seg_reg;
        res_status_next = res_status_reg;
        res_seg_next    = res_seg_reg;
        res_bytes_next  = res_bytes_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg[SEG_W-1:0];
        mem_wdata       = '0;
        mem_raddr       = cur_reg[SEG_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SEG_W'(1);
            end
            S_FMT_ROOT:
            begin
                mem_we    = 1'b1;
                mem_waddr = start_reg;
                mem_wdata = arena_ok ? mk_hdr(1'b1, fbytes_reg[SIZE_W-1:0], 1'b1, 1'b0)
                                     : mk_hdr(1'b1, '0, 1'b0, 1'b1);
            end
            S_FMT_END:
            begin
                mem_we    = arena_ok;
                mem_waddr = end_reg;
                mem_wdata = mk_hdr(1'b1, '0, 1'b0, 1'b1);
            end
            S_IDLE:
            begin
                mem_raddr = block_segment;
                if (in_acc)
                begin
                    func_next       = func;
                    req_next        = {1'b0, request_bytes};
                    seg_next        = block_segment;
                    exact_next      = exact_fit;
                    cur_next        = {2'b00, start_reg};
                    best_next       = '0;
                    res_status_next = 1'b1;
                    res_seg_next    = '0;
                    res_bytes_next  = '0;
                    if (func == FUNC_QUERY)
                    begin
                        res_status_next = 1'b0;
                    end
                end
            end
            S_WALK_RD:
            begin
                mem_raddr = cur_reg[SEG_W-1:0];
            end
            S_WALK_CHK:
            begin
                if (!walk_stop)
                begin
                    if (mem_rdata[HB_FREE])
                    begin
                        hdr_next = mem_rdata;
                        sz_next  = rd_size;
                        nx_next  = next_seg(cur_reg, rd_size);
                    end
                    else
                    begin
                        cur_next = next_seg(cur_reg, rd_size);
                    end
                end
            end
            S_COL_RD:
            begin
                mem_raddr = nx_reg[SEG_W-1:0];
            end
            S_COL_CHK:
            begin
                if (rd_free)
                begin
                    // Absorb the following free block and clear its header.
                    sz_next   = {col_sum[SIZE_W-1:2], 2'b00};
                    nx_next   = next_seg(cur_reg, {col_sum[SIZE_W-1:2], 2'b00});
                    mem_we    = 1'b1;
                    mem_waddr = nx_reg[SEG_W-1:0];
                    mem_wdata = '0;
                end
            end
            S_COL_END:
            begin
                if (func_reg == FUNC_RESIZE)
                begin
                    req_next = req_adj;
                end
                else if (!(func_reg == FUNC_ALLOC && col_fit))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg[SEG_W-1:0];
                    mem_wdata = {hdr_reg[HDR_W-1:21], sz_reg[20:2], hdr_reg[1:0]};
                    if (sz_reg > best_reg)
                    begin
                        best_next = sz_reg;
                    end
                    if (func_reg == FUNC_QUERY)
                    begin
                        res_bytes_next = (sz_reg > best_reg) ? sz_reg : best_reg;
                    end
                    cur_next = next_seg(cur_reg, sz_reg);
                end
            end
            S_SHAPE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = cur_reg[SEG_W-1:0];
                mem_wdata       = mk_hdr(1'b1, nsz_calc, 1'b0, 1'b0);
                nsz_next        = nsz_calc;
                res_status_next = 1'b0;
                res_seg_next    = cur_reg[SEG_W-1:0];
                if (func_reg == FUNC_ALLOC)
                begin
                    bcount_next = bcount_reg + CNT_W'(1);
                    fbytes_next = fbytes_reg - {{(FB_W-SIZE_W){1'b0}}, nsz_calc};
                end
                else
                begin
                    fbytes_next    = fbytes_reg + {{(FB_W-SIZE_W){1'b0}}, org_reg}
                                     - {{(FB_W-SIZE_W){1'b0}}, nsz_calc};
                    res_bytes_next = req_reg;
                end
            end
            S_SPLIT:
            begin
                mem_we    = (split_seg[NSEG_W-1:SEG_W] == '0);
                mem_waddr = split_seg[SEG_W-1:0];
                mem_wdata = mk_hdr(1'b1, sz_reg - nsz_reg - SIZE_W'(4), 1'b1, 1'b0);
            end
            S_BLK_CHK:
            begin
                if (blk_ok)
                begin
                    if (func_reg == FUNC_FREE)
                    begin
                        bcount_next     = bcount_reg - CNT_W'(1);
                        fbytes_next     = fbytes_reg + {{(FB_W-SIZE_W){1'b0}}, rd_size};
                        mem_we          = 1'b1;
                        mem_waddr       = seg_reg;
                        mem_wdata       = mem_rdata | (HDR_W'(1) << HB_FREE);
                        res_status_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = {2'b00, seg_reg};
                        hdr_next = mem_rdata;
                        sz_next  = rd_size;
                        org_next = rd_size;
                        nx_next  = next_seg({2'b00, seg_reg}, rd_size);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_wr)
        begin
            start_next   = new_start;
            end_next     = new_end;
            fbytes_next  = fmt_free(new_start, new_end);
            bcount_next  = '0;
            clr_cnt_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_seg_next    = out_seg_reg;
        out_bytes_next  = out_bytes_reg;
        out_count_next  = out_count_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_seg_next    = res_seg_reg;
            out_bytes_next  = res_bytes_reg;
            out_count_next  = bcount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            start_reg     <= START_RESET;
            end_reg       <= END_RESET;
            clr_cnt_reg   <= '0;
            fbytes_reg    <= FB_RESET;
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            clr_cnt_reg   <= clr_cnt_next;
            fbytes_reg    <= fbytes_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        nx_reg         <= nx_next;
        hdr_reg        <= hdr_next;
        sz_reg         <= sz_next;
        org_reg        <= org_next;
        best_reg       <= best_next;
        req_reg        <= req_next;
        nsz_reg        <= nsz_next;
        func_reg       <= func_next;
        exact_reg      <= exact_next;
        seg_reg        <= seg_next;
        res_status_reg <= res_status_next;
        res_seg_reg    <= res_seg_next;
        res_bytes_reg  <= res_bytes_next;
        out_status_reg <= out_status_next;
        out_seg_reg    <= out_seg_next;
        out_bytes_reg  <= out_bytes_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign result_segment   = out_seg_reg;
    assign result_bytes     = out_bytes_reg;
    assign allocated_blocks = out_count_reg;

`ifndef SYNTHESIS
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result item appeared outside the response step");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("header RAM written while idle");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SHAPE && state_reg != S_BLK_CHK && !cfg_wr) |=> $stable(bcount_reg))
        else $error("block count changed outside shape or free");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for first_fit_paragraph_allocator
// A directed table and then constrained-by-hand random traffic drive the
// request channel. Every result item is checked, for typed directed rows
// against the row's own expected result and else against an in-bench model
// of the header chain, and the arena is reformatted through the APB port
// between phases.
`default_nettype none

module tb;
    import ffpa_pkg::*;

    localparam int          LIMIT_CYCLES = 4000000;
    localparam logic [31:0] H_TERM  = 32'h0000_0001;
    localparam logic [31:0] H_FREE  = 32'h0000_0002;
    localparam logic [31:0] H_SIZE  = 32'h001F_FFFC;
    localparam logic [31:0] H_VALID = 32'h0040_0000;

    typedef struct packed {
        logic        st;
        logic [15:0] seg;
        logic [20:0] nbytes;
        logic [15:0] cnt;
    } alloc_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [19:0] req;
        logic [15:0] seg;
        logic        exact;
        bit          typed;
        alloc_res_t  res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] func;
    logic [REQ_W-1:0] request_bytes;
    logic [SEG_W-1:0] block_segment;
    logic exact_fit;
    logic status;
    logic [SEG_W-1:0] result_segment;
    logic [SIZE_W-1:0] result_bytes;
    logic [CNT_W-1:0] allocated_blocks;

    first_fit_paragraph_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .request_bytes(request_bytes), .block_segment(block_segment),
        .exact_fit(exact_fit),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .result_segment(result_segment), .result_bytes(result_bytes),
        .allocated_blocks(allocated_blocks)
    );

    // Model of the arena.
    logic [22:0] hstore [0:65535];
    logic [31:0] free_total;
    logic [15:0] live_count;
    logic [15:0] arena_lo, arena_hi;

    alloc_res_t  expected_q [$];
    logic [15:0] live_segs [$];
    int mismatches;
    int results_seen;
    int items_sent;
    int cycle_no;

    function automatic logic [31:0] hget(input logic [31:0] s);
        return (s < 65536) ? {9'd0, hstore[s[15:0]]} : 32'd0;
    endfunction

    function automatic void hput(input logic [31:0] s, input logic [31:0] v);
        if (s < 65536) hstore[s[15:0]] = v[22:0];
    endfunction

    function automatic logic [31:0] seg_after(input logic [31:0] s, input logic [31:0] sz);
        return s + ((sz + 32'd4) >> 4);
    endfunction

    function automatic bit hdr_is_free(input logic [31:0] h);
        return (h & H_VALID) != 0 && (h & H_FREE) != 0;
    endfunction

    // Segments are 16 bits wide, so clamping to the store is a no-op here.
    function automatic void format_arena();
        for (int i = 0; i < 65536; i++) hstore[i] = '0;
        live_count = '0;
        if (arena_hi <= arena_lo) begin
            hput(arena_lo, H_VALID | H_TERM);
            free_total = '0;
        end
        else begin
            free_total = (32'(arena_hi) - 32'(arena_lo)) * 32'd16 - 32'd4;
            hput(arena_lo, H_VALID | H_FREE | free_total);
            hput(arena_hi, H_VALID | H_TERM);
        end
    endfunction

    function automatic logic [31:0] merge_following(input logic [31:0] s);
        logic [31:0] h, sz, nx;
        int n;
        h  = hget(s);
        sz = h & H_SIZE;
        nx = seg_after(s, sz);
        n  = 0;
        while (n < 65536 && hdr_is_free(hget(nx))) begin
            sz = (sz + 32'd4 + (hget(nx) & H_SIZE)) & H_SIZE;
            hput(nx, 0);
            nx = seg_after(s, sz);
            n++;
        end
        hput(s, (h & ~H_SIZE) | sz);
        return sz;
    endfunction

    function automatic logic [31:0] carve_block(input logic [31:0] s, input logic [31:0] req,
                                                input logic [31:0] bsz);
        logic [31:0] nsz;
        if (bsz - req > 32'h20) begin
            nsz = ((req + 32'hF + 32'd4) & ~32'hF) - 32'd4;
            hput(s, H_VALID | nsz);
            hput(seg_after(s, nsz), H_VALID | H_FREE | ((bsz - nsz - 32'd4) & H_SIZE));
            return nsz;
        end
        hput(s, H_VALID | bsz);
        return bsz;
    endfunction

    function automatic bit owned_block(input logic [31:0] s);
        logic [31:0] h;
        h = hget(s);
        return s >= arena_lo && s < arena_hi && (h & H_VALID) != 0
               && (h & (H_FREE | H_TERM)) == 0;
    endfunction

    function automatic alloc_res_t predict_request(input logic [1:0] op,
                                                   input logic [19:0] req_in,
                                                   input logic [15:0] seg_in,
                                                   input logic exact);
        alloc_res_t r;
        logic [31:0] req, cur, best, h, bs, nsz, org;
        int steps;
        r   = '0;
        r.st = 1'b1;
        req = 32'(req_in);
        cur = 32'(arena_lo);
        steps = 0;
        best = 0;
        if (op == FUNC_ALLOC || op == FUNC_QUERY) begin
            if (op == FUNC_ALLOC && req > free_total) cur = 65536;
            while (steps < 65536) begin
                h = hget(cur);
                if ((h & H_VALID) == 0 || h == (H_VALID | H_TERM)) break;
                steps++;
                if ((h & H_FREE) != 0) begin
                    bs = merge_following(cur);
                    if (op == FUNC_ALLOC && bs >= req) begin
                        nsz = carve_block(cur, req, bs);
                        live_count = live_count + 16'd1;
                        free_total = free_total - nsz;
                        r.st  = 1'b0;
                        r.seg = cur[15:0];
                        break;
                    end
                    if (bs > best) best = bs;
                end
                else begin
                    bs = h & H_SIZE;
                end
                cur = seg_after(cur, bs);
            end
            if (op == FUNC_QUERY) begin
                r.st = 1'b0;
                r.nbytes = best[20:0];
            end
        end
        else if (op == FUNC_FREE) begin
            if (owned_block(seg_in)) begin
                h = hget(seg_in);
                live_count = live_count - 16'd1;
                free_total = free_total + (h & H_SIZE);
                hput(seg_in, h | H_FREE);
                r.st = 1'b0;
            end
        end
        else begin
            if (owned_block(seg_in)) begin
                org = hget(seg_in) & H_SIZE;
                bs  = merge_following(seg_in);
                if (bs < req) req = exact ? org : bs;
                nsz = carve_block(seg_in, req, bs);
                free_total = free_total + org - nsz;
                r.st = 1'b0;
                r.seg = seg_in;
                r.nbytes = req[20:0];
            end
        end
        r.cnt = live_count;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and the checker.
    int hold_left;
    bit held_once;
    always @(posedge clk or negedge rst_n)
    begin
        alloc_res_t got, want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
            held_once = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got = '{status, result_segment, result_bytes, allocated_blocks};
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %p", got);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (!held_once && results_seen >= 400) begin
                held_once = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= !(($urandom_range(0, 99) < 9)
                               && !(results_seen >= 600 && results_seen < 850));
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= a; pwdata <= {16'($urandom_range(0, 65535)), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == 0) arena_lo = v; else arena_hi = v;
        format_arena();
        live_segs.delete();
        // The clearing pass starts right after the write; wait it out.
        repeat (3) @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Drive one request and hold it until accepted, then update the model.
    // The caller is at a rising edge; the item is offered from this edge on.
    task automatic send_request(input stim_row_t row);
        alloc_res_t r;
        int k;
        in_valid <= 1'b1;
        func <= row.op; request_bytes <= row.req;
        block_segment <= row.seg; exact_fit <= row.exact;
        do @(posedge clk); while (!in_ready);
        r = predict_request(row.op, row.req, row.seg, row.exact);
        expected_q.push_back(row.typed ? row.res : r);
        items_sent++;
        if (row.op == FUNC_ALLOC && r.st == 1'b0) live_segs.push_back(r.seg);
        if (row.op == FUNC_FREE && r.st == 1'b0)
            for (k = 0; k < live_segs.size(); k++)
                if (live_segs[k] == row.seg) begin
                    live_segs.delete(k);
                    break;
                end
        if ($urandom_range(0, 99) < 9 && !(items_sent >= 600 && items_sent < 850)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        else begin
            // Keep valid high; the next item's payload is set at this same edge.
        end
    endtask

    task automatic random_traffic(input int n, input int max_req);
        stim_row_t row;
        int pick;
        for (int i = 0; i < n; i++) begin
            row = '{default: '0};
            pick = $urandom_range(0, 99);
            row.exact = 1'($urandom_range(0, 1));
            row.req = ($urandom_range(0, 19) == 0) ? 20'($urandom)
                                                  : 20'($urandom_range(0, max_req));
            row.seg = 16'($urandom);
            if (live_segs.size() != 0 && $urandom_range(0, 99) < 85)
                row.seg = live_segs[$urandom_range(0, live_segs.size() - 1)];
            if (pick < 40) row.op = FUNC_ALLOC;
            else if (pick < 70) row.op = FUNC_FREE;
            else if (pick < 85) row.op = FUNC_RESIZE;
            else row.op = FUNC_QUERY;
            if (items_sent == 700) drain_results();
            send_request(row);
        end
        drain_results();
    endtask

    stim_row_t directed [] = '{
        '{FUNC_QUERY,  20'd0,       16'd0,     1'b0, 1, '{1'b0, 16'd0, 21'd589804, 16'd0}},
        '{FUNC_ALLOC,  20'hFFFFF,   16'hFFFF,  1'b1, 1, '{1'b1, 16'd0, 21'd0, 16'd0}},
        '{FUNC_ALLOC,  20'd0,       16'd0,     1'b0, 0, '{default: '0}},
        '{FUNC_ALLOC,  20'd100,     16'd0,     1'b0, 0, '{default: '0}},
        '{FUNC_FREE,   20'd0,       16'd0,     1'b0, 1, '{1'b1, 16'd0, 21'd0, 16'd2}},
        '{FUNC_FREE,   20'd0,       16'hFFFF,  1'b1, 1, '{1'b1, 16'd0, 21'd0, 16'd2}},
        '{FUNC_FREE,   20'd0,       16'd4097,  1'b0, 0, '{default: '0}},
        '{FUNC_FREE,   20'd0,       16'd4097,  1'b0, 1, '{1'b1, 16'd0, 21'd0, 16'd1}},
        '{FUNC_RESIZE, 20'd1000,    16'd4098,  1'b0, 0, '{default: '0}},
        '{FUNC_RESIZE, 20'hFFFFF,   16'd4098,  1'b1, 0, '{default: '0}},
        '{FUNC_RESIZE, 20'hFFFFF,   16'd4098,  1'b0, 0, '{default: '0}},
        '{FUNC_RESIZE, 20'd0,       16'd4098,  1'b1, 0, '{default: '0}},
        '{FUNC_ALLOC,  20'd200,     16'd0,     1'b0, 0, '{default: '0}},
        '{FUNC_ALLOC,  20'd28,      16'd0,     1'b0, 0, '{default: '0}},
        '{FUNC_QUERY,  20'hFFFFF,   16'hFFFF,  1'b1, 0, '{default: '0}},
        '{FUNC_FREE,   20'd0,       16'd4098,  1'b0, 0, '{default: '0}},
        '{FUNC_RESIZE, 20'd16,      16'd40960, 1'b1, 1, '{1'b1, 16'd0, 21'd0, 16'd2}},
        '{FUNC_RESIZE, 20'd16,      16'd4096,  1'b0, 1, '{1'b1, 16'd0, 21'd0, 16'd2}},
        '{FUNC_ALLOC,  20'd589804,  16'd0,     1'b0, 0, '{default: '0}},
        '{FUNC_QUERY,  20'd0,       16'd0,     1'b0, 0, '{default: '0}}
    };

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; func = FUNC_ALLOC; request_bytes = '0;
        block_segment = '0; exact_fit = 1'b0;
        mismatches = 0; results_seen = 0; items_sent = 0; cycle_no = 0;
        arena_lo = START_RESET;
        arena_hi = END_RESET;
        format_arena();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (!in_ready) @(posedge clk);

        foreach (directed[i]) send_request(directed[i]);
        drain_results();
        random_traffic(300, 4000);

        // Small arena of forty paragraphs.
        apb_write(0, 16'd4097);
        apb_write(4, 16'd4137);
        random_traffic(300, 200);

        // Empty arena: end equal to start, then end below start.
        apb_write(0, 16'd100);
        apb_write(4, 16'd100);
        random_traffic(30, 64);
        apb_write(0, 16'hFFFF);
        apb_write(4, 16'd0);
        random_traffic(20, 64);

        // Whole store as one arena.
        apb_write(0, 16'd0);
        apb_write(4, 16'hFFFF);
        random_traffic(300, 8000);

        // Arena at the top of the store.
        apb_write(0, 16'd65000);
        apb_write(4, 16'd65535);
        random_traffic(280, 600);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
